/* src/ppd_pkg.sv */
// shared types and constants of the publish payload deframer
package ppd_pkg;

    // buffer slot sizes of the surrounding system
    localparam int CMD_SLOT_BYTES = 256;
    localparam int RX_SLOT_BYTES  = 1024;

    // field and state widths
    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 12;
    localparam int BUF_W    = 16;
    localparam int PKT_W    = 28;
    localparam int TOPIC_W  = 16;
    localparam int IDX_W    = 8;
    localparam int DIGIT_W  = 2;
    localparam int ERR_W    = 2;

    // derived limits
    localparam logic [LIMIT_W-1:0] KEEP_CAP    = LIMIT_W'(CMD_SLOT_BYTES - 3);
    localparam logic [BUF_W-1:0]   BUF_MAX     = BUF_W'(RX_SLOT_BYTES - 2);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(253);

    // configuration register indexes
    localparam logic REG_PAYLOAD_LIMIT = 1'b0;

    // parser phases
    typedef enum logic [2:0] {
        PH_LEN_HI     = 3'd0,
        PH_LEN_LO     = 3'd1,
        PH_HEADER     = 3'd2,
        PH_REMLEN     = 3'd3,
        PH_TOPIC_HI   = 3'd4,
        PH_TOPIC_LO   = 3'd5,
        PH_TOPIC_SKIP = 3'd6,
        PH_PAYLOAD    = 3'd7
    } t_phase;

    // result error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_LEN_LONG = 2'd1,
        ERR_TOPIC    = 2'd2,
        ERR_OVERRUN  = 2'd3
    } t_err;

    // one result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              payload_last;
        logic [IDX_W-1:0]  packet_number;
        t_err              error_code;
    } t_result;

endpackage

/* src/ppd_parser.sv */
// per-byte packet parser: state registers and next-state logic
module ppd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [ppd_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_buffer_start,
    input  logic [ppd_pkg::LIMIT_W-1:0] i_payload_limit,
    output logic                        o_res_valid,
    output ppd_pkg::t_result            o_res
);
    import ppd_pkg::*;

    t_phase              r_phase,  n_phase;
    logic [BUF_W-1:0]    r_buf,    n_buf;
    logic [PKT_W-1:0]    r_pkt,    n_pkt;
    logic [DIGIT_W-1:0]  r_cnt,    n_cnt;
    logic [TOPIC_W-1:0]  r_topic,  n_topic;
    logic [LIMIT_W-1:0]  r_kept,   n_kept;
    logic [IDX_W-1:0]    r_idx,    n_idx;

    logic [BUF_W-1:0]    buf_dec;
    logic [PKT_W-1:0]    pkt_dec;
    logic [TOPIC_W-1:0]  topic_dec;
    logic [BUF_W-1:0]    len_full;
    logic [TOPIC_W-1:0]  topic_full;
    logic [PKT_W-1:0]    digit_shifted;
    logic [PKT_W-1:0]    pkt_merged;
    logic [LIMIT_W-1:0]  keep_limit;
    logic                topic_done;
    logic                pkt_end;

    // clamp of the configured limit to the command slot
    assign keep_limit = (i_payload_limit < KEEP_CAP) ? i_payload_limit : KEEP_CAP;

    assign buf_dec    = r_buf - BUF_W'(1);
    assign pkt_dec    = r_pkt - PKT_W'(1);
    assign topic_dec  = r_topic - TOPIC_W'(1);
    assign len_full   = {r_buf[BUF_W-1:BYTE_W], i_in_byte};
    assign topic_full = {r_topic[TOPIC_W-1:BYTE_W], i_in_byte};

    // place one 7-bit length digit
    always_comb begin
        case (r_cnt)
            2'd0:    digit_shifted = PKT_W'(i_in_byte[6:0]);
            2'd1:    digit_shifted = PKT_W'(i_in_byte[6:0]) << 7;
            2'd2:    digit_shifted = PKT_W'(i_in_byte[6:0]) << 14;
            default: digit_shifted = PKT_W'(i_in_byte[6:0]) << 21;
        endcase
    end
    assign pkt_merged = r_pkt | digit_shifted;

    // next state and result for the byte being transferred
    always_comb begin
        n_phase    = r_phase;
        n_buf      = r_buf;
        n_pkt      = r_pkt;
        n_cnt      = r_cnt;
        n_topic    = r_topic;
        n_kept     = r_kept;
        n_idx      = r_idx;
        topic_done = 1'b0;
        pkt_end    = 1'b0;
        o_res_valid = 1'b0;
        o_res.out_byte      = '0;
        o_res.byte_valid    = 1'b0;
        o_res.payload_last  = 1'b0;
        o_res.packet_number = r_idx;
        o_res.error_code    = ERR_OK;

        if (i_buffer_start) begin
            n_buf   = {i_in_byte, {BYTE_W{1'b0}}};
            n_idx   = '0;
            n_phase = PH_LEN_LO;
        end else if (r_phase == PH_LEN_HI) begin
            // idle byte between buffers
        end else if (r_phase == PH_LEN_LO) begin
            n_buf = len_full;
            n_idx = '0;
            o_res.packet_number = '0;
            if (len_full == '0) begin
                n_phase = PH_LEN_HI;
            end else if (len_full > BUF_MAX) begin
                o_res_valid        = 1'b1;
                o_res.payload_last = 1'b1;
                o_res.error_code   = ERR_OVERRUN;
                n_phase            = PH_LEN_HI;
            end else begin
                n_phase = PH_HEADER;
            end
        end else if (r_buf == '0) begin
            // packet byte past the end of the buffer
            o_res_valid        = 1'b1;
            o_res.payload_last = 1'b1;
            o_res.error_code   = ERR_OVERRUN;
            n_phase            = PH_LEN_HI;
        end else begin
            n_buf = buf_dec;
            case (r_phase)
                PH_HEADER: begin
                    n_pkt   = '0;
                    n_cnt   = '0;
                    n_topic = '0;
                    n_kept  = '0;
                    n_phase = PH_REMLEN;
                end
                PH_REMLEN: begin
                    n_pkt = pkt_merged;
                    if (i_in_byte[7]) begin
                        if (r_cnt == 2'd3) begin
                            o_res_valid        = 1'b1;
                            o_res.payload_last = 1'b1;
                            o_res.error_code   = ERR_LEN_LONG;
                            n_phase            = PH_LEN_HI;
                        end else begin
                            n_cnt = r_cnt + 2'd1;
                        end
                    end else if (pkt_merged > PKT_W'(buf_dec)) begin
                        o_res_valid        = 1'b1;
                        o_res.payload_last = 1'b1;
                        o_res.error_code   = ERR_OVERRUN;
                        n_phase            = PH_LEN_HI;
                    end else if (pkt_merged < PKT_W'(2)) begin
                        o_res_valid        = 1'b1;
                        o_res.payload_last = 1'b1;
                        o_res.error_code   = ERR_TOPIC;
                        n_phase            = PH_LEN_HI;
                    end else begin
                        n_phase = PH_TOPIC_HI;
                    end
                end
                PH_TOPIC_HI: begin
                    n_topic = {i_in_byte, {BYTE_W{1'b0}}};
                    n_pkt   = pkt_dec;
                    n_phase = PH_TOPIC_LO;
                end
                PH_TOPIC_LO: begin
                    n_topic = topic_full;
                    n_pkt   = pkt_dec;
                    if (PKT_W'(topic_full) > pkt_dec) begin
                        o_res_valid        = 1'b1;
                        o_res.payload_last = 1'b1;
                        o_res.error_code   = ERR_TOPIC;
                        n_phase            = PH_LEN_HI;
                    end else if (topic_full != '0) begin
                        n_phase = PH_TOPIC_SKIP;
                    end else begin
                        topic_done = 1'b1;
                    end
                end
                PH_TOPIC_SKIP: begin
                    n_topic = topic_dec;
                    n_pkt   = pkt_dec;
                    if (topic_dec == '0) begin
                        topic_done = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_pkt   = pkt_dec;
                    pkt_end = (pkt_dec == '0);
                    if (r_kept < keep_limit) begin
                        n_kept             = r_kept + LIMIT_W'(1);
                        o_res_valid        = 1'b1;
                        o_res.out_byte     = i_in_byte;
                        o_res.byte_valid   = 1'b1;
                        o_res.payload_last = pkt_end;
                    end else if (pkt_end) begin
                        o_res_valid        = 1'b1;
                        o_res.payload_last = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // topic skipped: empty packet ends here, else payload follows
            if (topic_done) begin
                if (n_pkt == '0) begin
                    o_res_valid        = 1'b1;
                    o_res.payload_last = 1'b1;
                    pkt_end            = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end

            // packet finished: next packet or wait for a new buffer
            if (pkt_end) begin
                n_idx   = r_idx + IDX_W'(1);
                n_phase = (buf_dec == '0) ? PH_LEN_HI : PH_HEADER;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_HI;
            r_buf   <= '0;
            r_pkt   <= '0;
            r_cnt   <= '0;
            r_topic <= '0;
            r_kept  <= '0;
            r_idx   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_buf   <= n_buf;
            r_pkt   <= n_pkt;
            r_cnt   <= n_cnt;
            r_topic <= n_topic;
            r_kept  <= n_kept;
            r_idx   <= n_idx;
        end
    end

    // an error result always sends the parser back to waiting for a buffer
    a_err_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_res_valid && o_res.error_code != ERR_OK) |=> r_phase == PH_LEN_HI)
        else $error("parser did not return to idle after an error result");

    // every result carries a kept byte or ends a packet
    a_res_useful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.byte_valid || o_res.payload_last))
        else $error("result with neither a byte nor an end mark");

    // error results never carry a payload byte
    a_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error_code != ERR_OK) |-> !o_res.byte_valid)
        else $error("error result carries a payload byte");

endmodule

/* src/ppd_out_buf.sv */
// two-entry output buffer: result register plus skid register
module ppd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ppd_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output ppd_pkg::t_result o_res
);
    import ppd_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;
    assign o_ready = !r_skid_valid;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_res;
            end else begin
                r_main <= i_res;
            end
        end
    end

    // skid entry only holds data behind a waiting result
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry filled while result register empty");

    // a transfer out of a full buffer moves the skid entry forward
    a_skid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry lost on output transfer");

    // a push into a busy, stalled result register lands in the skid entry
    a_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_ready && r_main_valid && !i_ready) |=> r_skid_valid)
        else $error("result dropped while output stalled");

endmodule

/* src/publish_payload_deframer.sv */
// top level of the publish payload deframer: config register, parser, output buffer
//
// Usage: a received buffer is fed one byte per transfer on the input channel
// (i_valid/o_ready, i_in_byte, i_buffer_start set on the length high byte).
// The buffer holds a 16-bit big-endian total length and then back-to-back
// PUBLISH packets; payload bytes come out on the output channel
// (o_valid/i_ready), one result per kept byte, with o_payload_last on the
// result that ends a packet and o_error_code on a malformed buffer.
// Each result is registered in the result register, or in the skid register.
// Throughput: one byte per cycle while o_ready is high, one parser update per byte.
// The output side has a result register and a skid register; when the
// receiver stalls, one more result is absorbed and then o_ready drops until
// the receiver takes a result. While the skid register is full every byte
// waits, including bytes that make no result.
// Reset (synchronous, active low) empties both output entries, returns the
// parser to waiting for a buffer and sets payload_limit to 253. payload_limit
// is at APB byte address 0 and is to be written while idle; the block does not enforce it.
module publish_payload_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ppd_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_buffer_start,
    // output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ppd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_byte_valid,
    output logic                        o_payload_last,
    output logic [ppd_pkg::IDX_W-1:0]   o_packet_number,
    output logic [ppd_pkg::ERR_W-1:0]   o_error_code,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ppd_pkg::*;

    logic [LIMIT_W-1:0] r_payload_limit;
    logic               in_accept;
    logic               res_valid;
    t_result            res;
    t_result            out_res;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PAYLOAD_LIMIT) begin
            r_payload_limit <= pwdata[LIMIT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_PAYLOAD_LIMIT) ? {{(32-LIMIT_W){1'b0}}, r_payload_limit}
                                                    : 32'd0;

    assign in_accept = i_valid && o_ready;

    // byte parser
    ppd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_in_byte       (i_in_byte),
        .i_buffer_start  (i_buffer_start),
        .i_payload_limit (r_payload_limit),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // output buffer
    ppd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && res_valid),
        .i_res   (res),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_out_byte      = out_res.out_byte;
    assign o_byte_valid    = out_res.byte_valid;
    assign o_payload_last  = out_res.payload_last;
    assign o_packet_number = out_res.packet_number;
    assign o_error_code    = out_res.error_code;

    // a kept byte is never flagged with an error
    a_out_clean_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> o_error_code == ERR_OK)
        else $error("payload byte delivered with an error code");

    // input is refused only while results wait for the receiver
    a_ready_only_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input refused with no result pending");

    // a result the receiver refuses stays on the output
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_payload_last)))
        else $error("stalled result changed");

endmodule
